/* sv/sha_pkg.sv */
// Shared types, constants and helper functions for the SHA-256 engine.
// Used by sha_sched, sha_core, sha256_hash_engine and sha_checker.
`default_nettype none

package sha_pkg;

  localparam int WORD_W       = 32;
  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 64;
  localparam int DIGEST_WORDS = 8;

  localparam logic [WORD_W-1:0] PAD_MARKER      = 32'h8000_0000;
  localparam logic [2:0]        FULL_BYTES      = 3'd4;
  localparam logic [2:0]        DIGEST_LAST_IDX = 3'(DIGEST_WORDS - 1);
  localparam logic [3:0]        LEN_HI_SLOT     = 4'(BLOCK_WORDS - 2);
  localparam logic [3:0]        LAST_SLOT       = 4'(BLOCK_WORDS - 1);
  localparam logic [5:0]        LAST_ROUND      = 6'(ROUNDS - 1);

  // Request payload
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        final_item;
  } sha_in_t;

  // Result payload
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } sha_state_t;

  // Schedule window controls
  typedef struct packed {
    logic        push;
    logic [31:0] push_word;
    logic        expand;
  } sha_sched_ctrl_t;

  // Round unit controls
  typedef struct packed {
    logic load;
    logic round_en;
    logic feed;
    logic reinit;
  } sha_core_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash values
  function automatic logic [31:0] init_h(input logic [2:0] k);
    case (k)
      3'd0:    init_h = 32'h6a09e667;
      3'd1:    init_h = 32'hbb67ae85;
      3'd2:    init_h = 32'h3c6ef372;
      3'd3:    init_h = 32'ha54ff53a;
      3'd4:    init_h = 32'h510e527f;
      3'd5:    init_h = 32'h9b05688c;
      3'd6:    init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

/* sv/sha256_hash_engine.sv */
// SHA-256 engine top: request intake, padding sequencer, output of digest words.
// Depends on sha_pkg, sha_sched, sha_core.
// Each word of a block is taken while idle; the 16th word of a block starts 64
// rounds of the shared round unit, one round per cycle, then a feed-forward
// step, during which no request is taken. A final word adds padding words,
// one or two compressions, then 8 digest words at one per accepted cycle.
// Reset (rst, synchronous) idles the sequencer, clears counts, reloads initial H.
`default_nettype none

module sha256_hash_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             msg_valid,
  output logic                  msg_ready,
  input  wire sha_pkg::sha_in_t msg,
  output logic                  digest_valid,
  input  wire logic             digest_ready,
  output sha_pkg::sha_out_t     digest
);

  sha_pkg::sha_state_t      state, state_next;
  logic [3:0]               cnt, cnt_next;
  logic [5:0]               round, round_next;
  logic [63:0]              bit_count, bit_count_next;
  logic [2:0]               out_idx, out_idx_next;
  logic                     tail, tail_next;
  logic                     marker, marker_next;
  logic                     len_hi, len_hi_next;
  logic                     len_lo, len_lo_next;
  logic                     push_fire;
  logic [31:0]              push_val;
  logic [2:0]               vb_eff;
  logic [31:0]              w_t;
  logic [31:0]              cv_word;
  sha_pkg::sha_sched_ctrl_t sched_ctrl;
  sha_pkg::sha_core_ctrl_t  core_ctrl;

  sha_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_t  (w_t)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (core_ctrl),
    .round_idx (round),
    .w_t       (w_t),
    .out_idx   (out_idx),
    .cv_word   (cv_word)
  );

  // Clamp the byte count of the last word
  assign vb_eff = (msg.valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
                                                          : msg.valid_bytes;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_pkg::ST_IDLE;
      cnt       <= '0;
      round     <= '0;
      bit_count <= '0;
      out_idx   <= '0;
      tail      <= 1'b0;
      marker    <= 1'b0;
      len_hi    <= 1'b0;
      len_lo    <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      round     <= round_next;
      bit_count <= bit_count_next;
      out_idx   <= out_idx_next;
      tail      <= tail_next;
      marker    <= marker_next;
      len_hi    <= len_hi_next;
      len_lo    <= len_lo_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    round_next     = round;
    bit_count_next = bit_count;
    out_idx_next   = out_idx;
    tail_next      = tail;
    marker_next    = marker;
    len_hi_next    = len_hi;
    len_lo_next    = len_lo;
    push_fire      = 1'b0;
    push_val       = '0;
    msg_ready      = 1'b0;
    digest_valid   = 1'b0;
    sched_ctrl     = '0;
    core_ctrl      = '0;

    case (state)
      sha_pkg::ST_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          push_fire = 1'b1;
          if (!msg.final_item) begin
            push_val       = msg.message_word;
            bit_count_next = bit_count + 64'd32;
          end else begin
            tail_next      = 1'b1;
            state_next     = sha_pkg::ST_PAD;
            bit_count_next = bit_count + {58'd0, vb_eff, 3'b000};
            case (vb_eff)
              3'd0:    push_val = sha_pkg::PAD_MARKER;
              3'd1:    push_val = {msg.message_word[31:24], 8'h80, 16'h0000};
              3'd2:    push_val = {msg.message_word[31:16], 8'h80, 8'h00};
              3'd3:    push_val = {msg.message_word[31:8], 8'h80};
              default: begin
                push_val    = msg.message_word;
                marker_next = 1'b1;
              end
            endcase
          end
        end
      end
      sha_pkg::ST_PAD: begin
        push_fire = 1'b1;
        if (marker) begin
          push_val    = sha_pkg::PAD_MARKER;
          marker_next = 1'b0;
        end else if (len_hi) begin
          push_val    = bit_count[31:0];
          len_lo_next = 1'b1;
        end else if (cnt == sha_pkg::LEN_HI_SLOT) begin
          push_val    = bit_count[63:32];
          len_hi_next = 1'b1;
        end else begin
          push_val = '0;
        end
      end
      sha_pkg::ST_ROUND: begin
        core_ctrl.round_en = 1'b1;
        sched_ctrl.expand  = 1'b1;
        round_next         = round + 6'd1;
        if (round == sha_pkg::LAST_ROUND) begin
          state_next = sha_pkg::ST_FEED;
        end
      end
      sha_pkg::ST_FEED: begin
        core_ctrl.feed = 1'b1;
        if (len_lo) begin
          state_next = sha_pkg::ST_OUT;
        end else if (tail) begin
          state_next = sha_pkg::ST_PAD;
        end else begin
          state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_OUT: begin
        digest_valid = 1'b1;
        if (digest_ready) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == sha_pkg::DIGEST_LAST_IDX) begin
            core_ctrl.reinit = 1'b1;
            bit_count_next   = '0;
            tail_next        = 1'b0;
            marker_next      = 1'b0;
            len_hi_next      = 1'b0;
            len_lo_next      = 1'b0;
            state_next       = sha_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sha_pkg::ST_IDLE;
      end
    endcase

    // Push a word into the window; a full block starts the rounds
    if (push_fire) begin
      sched_ctrl.push      = 1'b1;
      sched_ctrl.push_word = push_val;
      cnt_next             = cnt + 4'd1;
      if (cnt == sha_pkg::LAST_SLOT) begin
        core_ctrl.load = 1'b1;
        round_next     = '0;
        state_next     = sha_pkg::ST_ROUND;
      end
    end
  end

  // Drive the result payload
  assign digest.digest_word  = cv_word;
  assign digest.digest_index = out_idx;
  assign digest.digest_last  = (out_idx == sha_pkg::DIGEST_LAST_IDX);

endmodule

`default_nettype wire

/* sv/sha_sched.sv */
// Message schedule window: 16-word shift line fed by pushes or by expansion.
// Depends on sha_pkg.
`default_nettype none

module sha_sched (
  input  wire logic                     clk,
  input  wire sha_pkg::sha_sched_ctrl_t ctrl,
  output logic [31:0]                   w_t
);

  logic [31:0] w [sha_pkg::BLOCK_WORDS];
  logic [31:0] expanded;
  logic [31:0] shift_in;

  // Next schedule word from the fixed taps
  assign expanded = sha_pkg::small_sigma1(w[14]) + w[9] + sha_pkg::small_sigma0(w[1]) + w[0];
  assign shift_in = ctrl.push ? ctrl.push_word : expanded;

  // Advance the window toward slot 0
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.expand) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[sha_pkg::BLOCK_WORDS - 1] <= shift_in;
    end
  end

  assign w_t = w[0];

endmodule

`default_nettype wire

/* sv/sha_core.sv */
// Shared round unit: working registers, one compression round per cycle,
// and the chaining values with feed-forward. Depends on sha_pkg.
`default_nettype none

module sha_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sha_pkg::sha_core_ctrl_t ctrl,
  input  wire logic [5:0]              round_idx,
  input  wire logic [31:0]             w_t,
  input  wire logic [2:0]              out_idx,
  output logic [31:0]                  cv_word
);

  logic [31:0] cv [sha_pkg::DIGEST_WORDS];
  logic [31:0] v  [sha_pkg::DIGEST_WORDS];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  // Round function
  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + sha_pkg::big_sigma1(v[4]) + choose + sha_pkg::round_k(round_idx) + w_t;
    t2 = sha_pkg::big_sigma0(v[0]) + major;
  end

  // Load or advance the working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int k = 0; k < sha_pkg::DIGEST_WORDS; k++) begin
        v[k] <= cv[k];
      end
    end else if (ctrl.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Hold chaining values; add the block result or reload initial values
  always_ff @(posedge clk) begin
    if (rst || ctrl.reinit) begin
      for (int k = 0; k < sha_pkg::DIGEST_WORDS; k++) begin
        cv[k] <= sha_pkg::init_h(3'(k));
      end
    end else if (ctrl.feed) begin
      for (int k = 0; k < sha_pkg::DIGEST_WORDS; k++) begin
        cv[k] <= cv[k] + v[k];
      end
    end
  end

  assign cv_word = cv[out_idx];

endmodule

`default_nettype wire

/* sv/sha_checker.sv */
// Port-level checks for sha256_hash_engine, attached by bind.
// Depends on sha_pkg.
`default_nettype none

module sha_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              msg_valid,
  input wire logic              msg_ready,
  input wire sha_pkg::sha_in_t  msg,
  input wire logic              digest_valid,
  input wire logic              digest_ready,
  input wire sha_pkg::sha_out_t digest
);

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=> (digest_valid && $stable(digest)))
    else $error("stalled digest word changed");

  // Drop request intake while digest words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("request taken during digest output");

  // Advance the digest index by one per accepted word
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && !digest.digest_last) |=>
      (digest_valid && (digest.digest_index == 3'($past(digest.digest_index) + 3'd1))))
    else $error("digest index did not advance");

  // Mark only the eighth word as last
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.digest_last == (digest.digest_index == sha_pkg::DIGEST_LAST_IDX)))
    else $error("digest_last does not match index");

  // Return to request intake after the last digest word
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest.digest_last) |=> (msg_ready && !digest_valid))
    else $error("engine not ready after digest");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_valid    (msg_valid),
  .msg_ready    (msg_ready),
  .msg          (msg),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest       (digest)
);

`default_nettype wire

/* sim/sha_checker.sv */
// Scoreboard for the SHA-256 engine: watches both handshakes, hashes every
// accepted request with its own model and compares each digest word in order.
// Depends on sha_pkg for the payload structs and padding constants.
`default_nettype none

module sha_scoreboard
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     msg_valid,
  input  wire logic     msg_ready,
  input  wire sha_in_t  msg,
  input  wire logic     digest_valid,
  input  wire logic     digest_ready,
  input  wire sha_out_t digest,
  output int            mismatch_count,
  output int            pending_words
);

  localparam logic [0:7][31:0] HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Model state: hash words, message schedule, block fill and message length
  logic [31:0] chain_h [8];
  logic [31:0] sched_w [16];
  logic [4:0]  fill_words;
  logic [63:0] msg_bits;
  sha_out_t    digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void load_initial();
    for (int k = 0; k < 8; k++) chain_h[k] = HASH_IV[k];
    fill_words = '0;
    msg_bits   = '0;
  endfunction

  // Run 64 rounds over the full schedule window and fold into the hash words
  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, w15, w2;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        w15 = sched_w[(t - 15) % 16];
        w2  = sched_w[(t - 2) % 16];
        sched_w[t % 16] = sched_w[t % 16]
          + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3))
          + sched_w[(t - 7) % 16]
          + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
      end
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[t] + sched_w[t % 16];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void push_block_word(input logic [31:0] w);
    sched_w[fill_words[3:0]] = w;
    fill_words++;
    if (fill_words == 5'd16) begin
      compress_block();
      fill_words = '0;
    end
  endfunction

  // Absorb one request; a final one pads, closes the message and queues the digest
  function automatic void hash_request(input sha_in_t req);
    int       nb;
    sha_out_t word_out;
    if (!req.final_item) begin
      msg_bits += 64'd32;
      push_block_word(req.message_word);
    end else begin
      nb = (req.valid_bytes > FULL_BYTES) ? int'(FULL_BYTES) : int'(req.valid_bytes);
      msg_bits += 64'(8 * nb);
      if (nb == 0) begin
        push_block_word(PAD_MARKER);
      end else if (nb == int'(FULL_BYTES)) begin
        push_block_word(req.message_word);
        push_block_word(PAD_MARKER);
      end else begin
        push_block_word((req.message_word & (32'hffff_ffff << (32 - 8 * nb)))
                        | (PAD_MARKER >> (8 * nb)));
      end
      while (fill_words != 5'(LEN_HI_SLOT)) push_block_word('0);
      push_block_word(msg_bits[63:32]);
      push_block_word(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        word_out.digest_word  = chain_h[k];
        word_out.digest_index = 3'(k);
        word_out.digest_last  = (3'(k) == DIGEST_LAST_IDX);
        digest_q.push_back(word_out);
      end
      load_initial();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Compare results before absorbing the request of the same edge
  always @(posedge clk) begin
    sha_out_t want;
    if (rst) begin
      load_initial();
      digest_q.delete();
      mismatch_count = 0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    digest.digest_word, digest.digest_index));
        end else begin
          want = digest_q.pop_front();
          if (digest.digest_word !== want.digest_word)
            report_mismatch($sformatf("digest word %0d: got %h, want %h",
                                      want.digest_index, digest.digest_word,
                                      want.digest_word));
          if (digest.digest_index !== want.digest_index)
            report_mismatch($sformatf("digest index: got %0d, want %0d",
                                      digest.digest_index, want.digest_index));
          if (digest.digest_last !== want.digest_last)
            report_mismatch($sformatf("digest last at index %0d: got %b, want %b",
                                      want.digest_index, digest.digest_last,
                                      want.digest_last));
        end
      end
      if (msg_valid && msg_ready) hash_request(msg);
    end
    pending_words <= digest_q.size();
  end

endmodule

`default_nettype wire

/* sim/sha256_hash_engine_tb.sv */
// Testbench top for sha256_hash_engine: drives clock, reset and message requests,
// throttles digest ready, and gives the verdict from the scoreboard's mismatch count.
// Depends on sha_pkg, sha256_hash_engine and sha_scoreboard.
`default_nettype none

module sha256_hash_engine_tb;
  import sha_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_REQUESTS = 95;

  logic     clk = 1'b0;
  logic     rst;
  logic     msg_valid;
  logic     msg_ready;
  sha_in_t  msg;
  logic     digest_valid;
  logic     digest_ready;
  sha_out_t digest;

  int   mismatch_count;
  int   pending_words;
  int   requests_sent;
  int   quiet_cycles;
  logic idle_on;

  sha256_hash_engine dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  sha_scoreboard u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .msg            (msg),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest         (digest),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always #10 clk = ~clk;

  // Throttle digest ready about 15 percent of cycles while idling is on
  always @(posedge clk) begin
    digest_ready <= !idle_on || ($urandom_range(99) >= 15);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (digest_valid && digest_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                              input logic last);
    sha_in_t req;
    req.message_word = word;
    req.valid_bytes  = nbytes;
    req.final_item   = last;
    if (idle_on && $urandom_range(99) < 15) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= req;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Send full words with random ignored byte counts, then a random final word
  task automatic send_message(input int n_words);
    for (int i = 0; i < n_words; i++)
      send_request($urandom, 3'($urandom_range(7)), 1'b0);
    send_request($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    msg_valid     = 1'b0;
    msg           = '0;
    idle_on       = 1'b1;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Short messages: empty, one to three bytes, full word, oversized byte count
    send_request(32'hffff_ffff, 3'd0, 1'b1);
    send_request(32'hffff_ffff, 3'd1, 1'b1);
    send_request(32'h0000_0000, 3'd2, 1'b1);
    send_request(32'h6162_6300, 3'd3, 1'b1);
    send_request(32'h0000_0000, FULL_BYTES, 1'b1);
    send_request(32'hffff_ffff, 3'd7, 1'b1);
    // Byte count ignored on a non-final word; above four on the final one
    send_request(32'hffff_ffff, 3'd7, 1'b0);
    send_request(32'ha5a5_a5a5, 3'd5, 1'b1);
    // Fourteen words: padding spills into a second block
    send_request(32'h0000_0000, 3'd0, 1'b0);
    send_request(32'hffff_ffff, 3'd6, 1'b0);
    for (int i = 0; i < 11; i++) send_request($urandom, 3'd4, 1'b0);
    send_request(32'h0123_4567, FULL_BYTES, 1'b1);

    // Random messages, mostly under two blocks; a quiet stretch with no idling
    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      idle_on = !(requests_sent >= 45 && requests_sent < 85);
      if ($urandom_range(9) < 7) send_message($urandom_range(17));
      else send_message($urandom_range(40, 12));
    end
    msg_valid <= 1'b0;
    idle_on = 1'b1;

    // Drain outstanding digest words, then settle
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
